// ===== rtl/srsf_pkg.sv =====
// srsf_pkg: shared types and constants of the sonar range spike filter
// used by srsf_lane, srsf_merge and sonar_range_spike_filter; no dependencies
package srsf_pkg;

    localparam int CHANNEL_COUNT = 3;
    localparam int DIST_BITS     = 10;
    localparam int RAW_BITS      = 11;
    localparam int SUM_BITS      = 12;
    localparam int MEAN_BITS     = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam int US_PER_CM     = 58;

    // widths at or above this give a distance past every compare limit
    localparam int SAT_WIDTH     = (1 << RAW_BITS) * US_PER_CM;
    localparam int NARROW_BITS   = 17;

    // floor(w / 58) = (w * RECIP_CM) >> CM_SHIFT for w below SAT_WIDTH
    localparam int CM_SHIFT      = 24;
    localparam int RECIP_BITS    = 19;
    localparam int RECIP_CM      = ((1 << CM_SHIFT) + US_PER_CM - 1) / US_PER_CM;
    localparam int CM_PROD_BITS  = NARROW_BITS + RECIP_BITS;

    // floor(s * 64 / 3) = (s * RECIP_MEAN) >> MEAN_SHIFT for any 12-bit sum
    localparam int MEAN_SHIFT    = 14;
    localparam int RECIP_MEAN    = ((64 << MEAN_SHIFT) + 2) / 3;
    localparam int MEAN_PROD_BITS = SUM_BITS + RECIP_BITS;

    localparam logic [DIST_BITS-1:0] MAX_DISTANCE_RESET = 10'd600;
    localparam logic [DIST_BITS-1:0] JUMP_LIMIT_RESET   = 10'd300;

    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [MEAN_BITS-1:0] mean_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MAX_DISTANCE = 2'd0,
        REG_JUMP_LIMIT   = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic load;   // new word enters the first stage
        logic step;   // first-stage word moves into the history stage
    } pipe_ctrl_t;

endpackage

// ===== rtl/sonar_range_spike_filter.sv =====
// sonar_range_spike_filter: three-channel sonar range clamp, spike reject and mean
// depends on srsf_pkg, srsf_lane and srsf_merge
//
//   channel  handshake               word
//   in       in_valid / in_ready     echo_width_a..c, fresh_a..c
//   out      out_valid / out_ready   smoothed_a..c
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one word per cycle while no output word is held; a word is distance-multiplied as
// it is taken, then history-updated, then mean-multiplied into the output register
// all three lanes and the output register step together on one enable
// a held output word stops every stage and drops in_ready
// reset clears held widths and history and loads 600 / 300 into the registers
module sonar_range_spike_filter #(
    parameter int WIDTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WIDTH_BITS-1:0] echo_width_a,
    input  logic [WIDTH_BITS-1:0] echo_width_b,
    input  logic [WIDTH_BITS-1:0] echo_width_c,
    input  logic                  fresh_a,
    input  logic                  fresh_b,
    input  logic                  fresh_c,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           smoothed_a,
    output logic [15:0]           smoothed_b,
    output logic [15:0]           smoothed_c,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [srsf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [srsf_pkg::DIST_BITS-1:0]      cfg_data
);

    srsf_pkg::dist_t max_distance_reg, max_distance_next;
    srsf_pkg::dist_t jump_limit_reg, jump_limit_next;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic advance;
    srsf_pkg::pipe_ctrl_t ctrl;

    logic [WIDTH_BITS-1:0] widths [srsf_pkg::CHANNEL_COUNT];
    logic                  fresh  [srsf_pkg::CHANNEL_COUNT];
    srsf_pkg::mean_t       lane_mean [srsf_pkg::CHANNEL_COUNT];
    srsf_pkg::mean_t       smoothed  [srsf_pkg::CHANNEL_COUNT];

    assign widths[0] = echo_width_a;
    assign widths[1] = echo_width_b;
    assign widths[2] = echo_width_c;
    assign fresh[0]  = fresh_a;
    assign fresh[1]  = fresh_b;
    assign fresh[2]  = fresh_c;

    assign smoothed_a = smoothed[0];
    assign smoothed_b = smoothed[1];
    assign smoothed_c = smoothed[2];

    assign cfg_ready = 1'b1;
    assign in_ready  = advance;
    assign ctrl.load = in_valid && advance;
    assign ctrl.step = v1_reg && advance;
    assign v1_next   = advance ? in_valid : v1_reg;
    assign v2_next   = advance ? v1_reg : v2_reg;

    // register write decode
    always_comb
    begin
        max_distance_next = max_distance_reg;
        jump_limit_next   = jump_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (srsf_pkg::reg_index_t'(cfg_index))
                srsf_pkg::REG_MAX_DISTANCE: max_distance_next = cfg_data;
                srsf_pkg::REG_JUMP_LIMIT:   jump_limit_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= srsf_pkg::MAX_DISTANCE_RESET;
            jump_limit_reg   <= srsf_pkg::JUMP_LIMIT_RESET;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
        end
        else
        begin
            max_distance_reg <= max_distance_next;
            jump_limit_reg   <= jump_limit_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
        end
    end

    for (genvar ch = 0; ch < srsf_pkg::CHANNEL_COUNT; ch++)
    begin : g_lane
        srsf_lane #(
            .WIDTH_BITS (WIDTH_BITS)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .echo_width   (widths[ch]),
            .fresh        (fresh[ch]),
            .max_distance (max_distance_reg),
            .jump_limit   (jump_limit_reg),
            .mean         (lane_mean[ch])
        );
    end

    srsf_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes_valid (v2_reg),
        .lane_mean   (lane_mean),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .smoothed    (smoothed),
        .advance     (advance)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output word held");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted word lost before first stage");

    a_stage1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && advance) |=> v2_reg)
        else $error("first-stage word lost before history stage");

    a_output_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v2_reg))
        else $error("output word appeared without a history-stage word");

endmodule

// ===== rtl/srsf_lane.sv =====
// srsf_lane: one channel of the filter, width hold, distance, spike reject, mean
// depends on srsf_pkg
module srsf_lane #(
    parameter int WIDTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srsf_pkg::pipe_ctrl_t   ctrl,
    input  logic [WIDTH_BITS-1:0]  echo_width,
    input  logic                   fresh,
    input  srsf_pkg::dist_t        max_distance,
    input  srsf_pkg::dist_t        jump_limit,
    output srsf_pkg::mean_t        mean
);

    logic [WIDTH_BITS-1:0] held_width_reg, held_width_next;
    logic [srsf_pkg::RAW_BITS-1:0] dist_reg, dist_next;
    srsf_pkg::dist_t kept_prev_reg, kept_prev_next;
    srsf_pkg::dist_t kept_prev_prev_reg, kept_prev_prev_next;
    logic [srsf_pkg::SUM_BITS-1:0] sum_reg, sum_next;

    logic [32:0] width_ext;
    logic [srsf_pkg::NARROW_BITS-1:0] width_narrow;
    logic [srsf_pkg::CM_PROD_BITS-1:0] cm_prod;
    logic sat;
    logic over_max;
    logic spike;
    srsf_pkg::dist_t clamped;
    srsf_pkg::dist_t kept;
    logic [srsf_pkg::MEAN_PROD_BITS-1:0] mean_prod;

    // stage one: held width and distance
    always_comb
    begin
        held_width_next = fresh ? echo_width : held_width_reg;
        width_ext       = 33'(held_width_next);
        sat             = width_ext >= 33'(srsf_pkg::SAT_WIDTH);
        width_narrow    = width_ext[srsf_pkg::NARROW_BITS-1:0];
        cm_prod         = srsf_pkg::CM_PROD_BITS'(width_narrow)
                        * srsf_pkg::CM_PROD_BITS'(srsf_pkg::RECIP_CM);
        dist_next       = sat ? {srsf_pkg::RAW_BITS{1'b1}}
                              : cm_prod[srsf_pkg::CM_SHIFT +: srsf_pkg::RAW_BITS];
    end

    // stage two: clamp, spike reject, history, sum
    always_comb
    begin
        over_max = dist_reg > srsf_pkg::RAW_BITS'(max_distance);
        clamped  = over_max ? max_distance : dist_reg[srsf_pkg::DIST_BITS-1:0];
        spike    = dist_reg > (srsf_pkg::RAW_BITS'(kept_prev_reg)
                             + srsf_pkg::RAW_BITS'(jump_limit));
        kept     = (spike && (kept_prev_reg != '0) && (kept_prev_prev_reg != '0))
                 ? kept_prev_reg : clamped;
        kept_prev_next      = kept;
        kept_prev_prev_next = kept_prev_reg;
        sum_next = srsf_pkg::SUM_BITS'(kept) + srsf_pkg::SUM_BITS'(kept_prev_reg)
                 + srsf_pkg::SUM_BITS'(kept_prev_prev_reg);
    end

    // stage three: mean with 6 fraction bits
    always_comb
    begin
        mean_prod = srsf_pkg::MEAN_PROD_BITS'(sum_reg)
                  * srsf_pkg::MEAN_PROD_BITS'(srsf_pkg::RECIP_MEAN);
        mean      = mean_prod[srsf_pkg::MEAN_SHIFT +: srsf_pkg::MEAN_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_width_reg     <= '0;
            kept_prev_reg      <= '0;
            kept_prev_prev_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                held_width_reg <= held_width_next;
            end
            if (ctrl.step)
            begin
                kept_prev_reg      <= kept_prev_next;
                kept_prev_prev_reg <= kept_prev_prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dist_reg <= dist_next;
        end
        if (ctrl.step)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== rtl/srsf_merge.sv =====
// srsf_merge: gathers the lane means into one output word with its handshake
// depends on srsf_pkg
module srsf_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             lanes_valid,
    input  srsf_pkg::mean_t  lane_mean [srsf_pkg::CHANNEL_COUNT],
    input  logic             out_ready,
    output logic             out_valid,
    output srsf_pkg::mean_t  smoothed [srsf_pkg::CHANNEL_COUNT],
    output logic             advance
);

    logic out_valid_reg, out_valid_next;
    srsf_pkg::mean_t smoothed_reg [srsf_pkg::CHANNEL_COUNT];

    assign advance        = !out_valid_reg || out_ready;
    assign out_valid_next = advance ? lanes_valid : out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign smoothed       = smoothed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && lanes_valid)
        begin
            smoothed_reg <= lane_mean;
        end
    end

endmodule
